FILE: rtl/sbbn_pkg.sv
// Shared constants, payload types and helpers for the stroke bounding-box normalizer.
// No dependencies; every other file in rtl/ except sbbn_ram refers to this package by scoped names.
`default_nettype none

package sbbn_pkg;

	// Sizing
	localparam int MAX_POINTS = 64;   // points held per drawing, 2..64
	localparam int COORD_BITS = 16;   // coordinate bits kept, 8..32
	localparam int FIELD_BITS = 16;   // fixed width of the coordinate fields on the ports

	// The scaled range is 0..SCALE_TOP, so the quotient has QUO_BITS bits.
	// The divider retires two quotient bits a step, so QUO_BITS must be even.
	localparam int SCALE_TOP = 255;
	localparam int QUO_BITS  = 8;
	localparam int DIV_STEPS = QUO_BITS / 2;
	localparam int DIV_STEP_W = $clog2(DIV_STEPS);
	localparam int NUM_W = COORD_BITS + QUO_BITS;
	localparam int REM_W = COORD_BITS + 2;

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	// Two drawings in flight: one loading, one emitting.
	localparam int JOB_DEPTH  = 2;
	localparam int JOB_PTR_W  = $clog2(JOB_DEPTH);
	localparam int JOB_CNT_W  = $clog2(JOB_DEPTH + 1);
	localparam int RAM_DEPTH  = JOB_DEPTH << IDX_W;
	localparam int RAM_AW     = JOB_PTR_W + IDX_W;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [FIELD_BITS-1:0] field_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [JOB_PTR_W-1:0]  jptr_t;
	typedef logic [JOB_CNT_W-1:0]  jcnt_t;
	typedef logic [RAM_AW-1:0]     ram_addr_t;
	typedef logic [QUO_BITS-1:0]   quo_t;
	typedef logic [NUM_W-1:0]      num_t;
	typedef logic [REM_W-1:0]      rem_t;
	typedef logic [DIV_STEP_W-1:0] step_t;

	localparam cnt_t   CNT_MAX   = cnt_t'(MAX_POINTS);
	localparam cnt_t   CNT_ONE   = cnt_t'(1);
	localparam jcnt_t  JOB_FULL  = jcnt_t'(JOB_DEPTH);
	localparam coord_t COORD_ONES = {COORD_BITS{1'b1}};
	localparam coord_t COORD_ZERO = {COORD_BITS{1'b0}};

	typedef struct packed {
		field_t x_coord;
		field_t y_coord;
		logic   stroke_end;
		logic   drawing_end;
	} point_t;

	typedef struct packed {
		field_t norm_x;
		field_t norm_y;
		logic   stroke_last;
		logic   run_last;
		logic   overflowed;
	} result_t;

	// One stored point
	typedef struct packed {
		logic   stroke;
		coord_t x;
		coord_t y;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Descriptor of a finished drawing handed from front to back
	typedef struct packed {
		cnt_t   count;
		coord_t min_x;
		coord_t max_x;
		coord_t min_y;
		coord_t max_y;
		logic   drop;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_LOAD,
		BK_DIV
	} back_state_t;

	function automatic coord_t to_coord(input field_t f);
		logic [FIELD_BITS+COORD_BITS-1:0] wide;
		wide = {{COORD_BITS{1'b0}}, f};
		return wide[COORD_BITS-1:0];
	endfunction

	function automatic field_t to_field(input coord_t c);
		logic [FIELD_BITS+COORD_BITS-1:0] wide;
		wide = {{FIELD_BITS{1'b0}}, c};
		return wide[FIELD_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/sbbn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sbbn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sbbn_front.sv
// Load side: takes points, writes them to the point RAM and tracks the bounding box.
// Depends on sbbn_pkg.
`default_nettype none

module sbbn_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire sbbn_pkg::point_t   point,
	input  wire logic               job_full,
	input  wire sbbn_pkg::jptr_t    bank,
	output      logic               wr_en,
	output      sbbn_pkg::ram_addr_t wr_addr,
	output      sbbn_pkg::entry_t   wr_data,
	output      logic               job_push,
	output      sbbn_pkg::job_t     job
);

	sbbn_pkg::cnt_t   count_q;
	sbbn_pkg::coord_t min_x_q, max_x_q, min_y_q, max_y_q;
	logic             drop_q;

	logic             accept;
	logic             room;
	sbbn_pkg::coord_t x, y;
	sbbn_pkg::job_t   nxt;

	assign accept = push && !job_full;
	assign room   = (count_q != sbbn_pkg::CNT_MAX);
	assign x      = sbbn_pkg::to_coord(point.x_coord);
	assign y      = sbbn_pkg::to_coord(point.y_coord);

	// Bounds and count as they stand once this request is taken in
	always_comb begin
		nxt.count = count_q;
		nxt.min_x = min_x_q;
		nxt.max_x = max_x_q;
		nxt.min_y = min_y_q;
		nxt.max_y = max_y_q;
		nxt.drop  = drop_q;
		if (room) begin
			nxt.count = count_q + sbbn_pkg::CNT_ONE;
			if (x < min_x_q) nxt.min_x = x;
			if (x > max_x_q) nxt.max_x = x;
			if (y < min_y_q) nxt.min_y = y;
			if (y > max_y_q) nxt.max_y = y;
		end else begin
			nxt.drop = 1'b1;
		end
	end

	assign wr_en        = accept && room;
	assign wr_addr      = {bank, count_q[sbbn_pkg::IDX_W-1:0]};
	assign wr_data.stroke = point.stroke_end;
	assign wr_data.x    = x;
	assign wr_data.y    = y;
	assign job_push     = accept && point.drawing_end;
	assign job          = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_x_q <= sbbn_pkg::COORD_ONES;
			max_x_q <= sbbn_pkg::COORD_ZERO;
			min_y_q <= sbbn_pkg::COORD_ONES;
			max_y_q <= sbbn_pkg::COORD_ZERO;
			drop_q  <= 1'b0;
		end else if (accept) begin
			if (point.drawing_end) begin
				count_q <= '0;
				min_x_q <= sbbn_pkg::COORD_ONES;
				max_x_q <= sbbn_pkg::COORD_ZERO;
				min_y_q <= sbbn_pkg::COORD_ONES;
				max_y_q <= sbbn_pkg::COORD_ZERO;
				drop_q  <= 1'b0;
			end else begin
				count_q <= nxt.count;
				min_x_q <= nxt.min_x;
				max_x_q <= nxt.max_x;
				min_y_q <= nxt.min_y;
				max_y_q <= nxt.max_y;
				drop_q  <= nxt.drop;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sbbn_pkg::CNT_MAX)
		else $error("front point count beyond buffer capacity");

endmodule

`default_nettype wire

FILE: rtl/sbbn_job_fifo.sv
// Two-entry queue of drawing descriptors between the load and emit sides.
// Its pointers double as the RAM bank of each drawing. Depends on sbbn_pkg.
`default_nettype none

module sbbn_job_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire sbbn_pkg::job_t  job_in,
	input  wire logic            pop,
	output      logic            full,
	output      logic            valid,
	output      sbbn_pkg::job_t  head,
	output      sbbn_pkg::jptr_t wr_ptr,
	output      sbbn_pkg::jptr_t rd_ptr
);

	sbbn_pkg::job_t  slot_q [sbbn_pkg::JOB_DEPTH];
	sbbn_pkg::jptr_t wr_ptr_q, rd_ptr_q;
	sbbn_pkg::jcnt_t count_q;

	assign full   = (count_q == sbbn_pkg::JOB_FULL);
	assign valid  = (count_q != '0);
	assign head   = slot_q[rd_ptr_q];
	assign wr_ptr = wr_ptr_q;
	assign rd_ptr = rd_ptr_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= job_in;
		end
	end

	// Depth is a power of two, so the pointers wrap on their own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + sbbn_pkg::jptr_t'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + sbbn_pkg::jptr_t'(1);
			if (push && !pop)      count_q <= count_q + sbbn_pkg::jcnt_t'(1);
			else if (pop && !push) count_q <= count_q - sbbn_pkg::jcnt_t'(1);
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("job pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !valid))
		else $error("job popped from an empty queue");

endmodule

`default_nettype wire

FILE: rtl/sbbn_div.sv
// Radix-4 divider for one axis: floor(diff * 255 / span), two quotient bits a cycle.
// Depends on sbbn_pkg.
`default_nettype none

module sbbn_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire sbbn_pkg::coord_t diff,
	input  wire sbbn_pkg::coord_t span,
	output      logic             done,
	output      sbbn_pkg::quo_t   quo
);

	logic             busy_q, prep_q, done_q;
	sbbn_pkg::step_t  step_q;
	sbbn_pkg::coord_t diff_q, d1_q, rem_q;
	sbbn_pkg::rem_t   d3_q;
	sbbn_pkg::quo_t   low_q, quo_q;

	sbbn_pkg::num_t   num;
	sbbn_pkg::rem_t   r4, d1w, d2w, s1, s2, s3;
	logic [1:0]       digit;
	sbbn_pkg::coord_t rem_nxt;

	assign num = sbbn_pkg::num_t'(diff_q) * sbbn_pkg::num_t'(sbbn_pkg::SCALE_TOP);

	// Bring down two numerator bits, then try 3d, 2d and d side by side
	assign r4  = {rem_q, low_q[sbbn_pkg::QUO_BITS-1 -: 2]};
	assign d1w = {2'b00, d1_q};
	assign d2w = {1'b0, d1_q, 1'b0};
	assign s1  = r4 - d1w;
	assign s2  = r4 - d2w;
	assign s3  = r4 - d3_q;

	always_comb begin
		if (r4 >= d3_q) begin
			digit   = 2'd3;
			rem_nxt = s3[sbbn_pkg::COORD_BITS-1:0];
		end else if (r4 >= d2w) begin
			digit   = 2'd2;
			rem_nxt = s2[sbbn_pkg::COORD_BITS-1:0];
		end else if (r4 >= d1w) begin
			digit   = 2'd1;
			rem_nxt = s1[sbbn_pkg::COORD_BITS-1:0];
		end else begin
			digit   = 2'd0;
			rem_nxt = r4[sbbn_pkg::COORD_BITS-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			prep_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			prep_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && prep_q) begin
			prep_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + sbbn_pkg::step_t'(1);
			if (step_q == sbbn_pkg::step_t'(sbbn_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// The scaled numerator is below 256 * span, so its top part is a valid remainder
	always_ff @(posedge clk) begin
		if (start) begin
			diff_q <= diff;
			d1_q   <= span;
		end else if (busy_q && prep_q) begin
			d3_q  <= d1w + d2w;
			rem_q <= num[sbbn_pkg::NUM_W-1:sbbn_pkg::QUO_BITS];
			low_q <= num[sbbn_pkg::QUO_BITS-1:0];
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			low_q <= {low_q[sbbn_pkg::QUO_BITS-3:0], 2'b00};
			quo_q <= {quo_q[sbbn_pkg::QUO_BITS-3:0], digit};
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sbbn_back.sv
// Emit side: walks the stored points of the head drawing, scales them and holds results.
// Depends on sbbn_pkg and sbbn_div.
`default_nettype none

module sbbn_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                job_valid,
	input  wire sbbn_pkg::job_t      job,
	input  wire sbbn_pkg::jptr_t     job_bank,
	output      logic                job_pop,
	output      logic                rd_en,
	output      sbbn_pkg::ram_addr_t rd_addr,
	input  wire sbbn_pkg::entry_t    rd_data,
	input  wire logic                pop,
	output      logic                empty,
	output      sbbn_pkg::result_t   result
);

	sbbn_pkg::back_state_t state_q, state_d;
	sbbn_pkg::idx_t        idx_q, idx_d;
	logic                  stroke_q;
	logic                  out_valid_q;
	sbbn_pkg::result_t     out_q, out_d;

	logic             start, emit, out_free, last;
	logic             x_done, y_done;
	sbbn_pkg::quo_t   quo_x, quo_y;
	sbbn_pkg::coord_t span_x, span_y, diff_x, diff_y;
	logic             flat_x, flat_y;

	assign span_x   = job.max_x - job.min_x;
	assign span_y   = job.max_y - job.min_y;
	assign flat_x   = (job.max_x == job.min_x);
	assign flat_y   = (job.max_y == job.min_y);
	assign diff_x   = rd_data.x - job.min_x;
	assign diff_y   = rd_data.y - job.min_y;
	assign out_free = !out_valid_q || pop;
	assign last     = (sbbn_pkg::cnt_t'(idx_q) + sbbn_pkg::CNT_ONE == job.count);
	assign rd_addr  = {job_bank, idx_q};

	sbbn_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.diff   (diff_x),
		.span   (span_x),
		.done   (x_done),
		.quo    (quo_x)
	);

	sbbn_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.diff   (diff_y),
		.span   (span_y),
		.done   (y_done),
		.quo    (quo_y)
	);

	// Result fields; a flat axis reports its minimum
	always_comb begin
		out_d.norm_x = flat_x ? sbbn_pkg::to_field(job.min_x)
			: {{(sbbn_pkg::FIELD_BITS - sbbn_pkg::QUO_BITS){1'b0}}, quo_x};
		out_d.norm_y = flat_y ? sbbn_pkg::to_field(job.min_y)
			: {{(sbbn_pkg::FIELD_BITS - sbbn_pkg::QUO_BITS){1'b0}}, quo_y};
		out_d.stroke_last = stroke_q;
		out_d.run_last    = last;
		out_d.overflowed  = job.drop;
	end

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		rd_en   = 1'b0;
		start   = 1'b0;
		emit    = 1'b0;
		job_pop = 1'b0;
		case (state_q)
			sbbn_pkg::BK_IDLE: begin
				idx_d = '0;
				if (job_valid) state_d = sbbn_pkg::BK_READ;
			end
			sbbn_pkg::BK_READ: begin
				rd_en   = 1'b1;
				state_d = sbbn_pkg::BK_LOAD;
			end
			sbbn_pkg::BK_LOAD: begin
				start   = 1'b1;
				state_d = sbbn_pkg::BK_DIV;
			end
			sbbn_pkg::BK_DIV: begin
				if (x_done && y_done && out_free) begin
					emit = 1'b1;
					if (last) begin
						job_pop = 1'b1;
						state_d = sbbn_pkg::BK_IDLE;
					end else begin
						idx_d   = idx_q + sbbn_pkg::idx_t'(1);
						state_d = sbbn_pkg::BK_READ;
					end
				end
			end
			default: begin
				state_d = sbbn_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sbbn_pkg::BK_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (emit)     out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) stroke_q <= rd_data.stroke;
		if (emit)  out_q    <= out_d;
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	a_busy_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sbbn_pkg::BK_IDLE) |-> job_valid)
		else $error("emit side active without a queued drawing");

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		x_done == y_done)
		else $error("x and y dividers out of step");

endmodule

`default_nettype wire

FILE: rtl/stroke_bounding_box_normalizer.sv
// Top level of the stroke bounding-box normalizer: load side, job queue, point RAM, emit side.
// Depends on sbbn_pkg, sbbn_ram, sbbn_front, sbbn_job_fifo and sbbn_back.
`default_nettype none

// Points of a drawing are pushed one per cycle. Each is stored in a point RAM
// while the smallest and largest x and y are tracked. The point carrying
// drawing_end is stored (if room is left) and closes the drawing: a
// descriptor with count, bounds and overflow flag goes into a two-entry queue,
// and the load side starts the next drawing in the other RAM bank at once.
// The emit side then reads the stored points in arrival order and returns one
// result per point, each coordinate scaled to floor((v - min) * 255 /
// (max - min)), or given as the axis minimum when that axis has zero span.
// run_last marks the final point of a drawing and overflowed is set on every
// result of a drawing that lost points to a full buffer (the extra points are
// dropped). Loading runs at one point per cycle; full rises only while two
// closed drawings are waiting or being emitted. Each point is emitted through
// a RAM read, a load into the radix-4 dividers, the forming of the scaled
// numerator and four two-bit quotient steps, then the hand-off into the result
// register once that register is free; a finished result waits in it while the
// next point is worked on. The RAM needs no clearing after reset.
module stroke_bounding_box_normalizer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output      logic              full,
	input  wire sbbn_pkg::point_t  point,
	output      logic              empty,
	input  wire logic              pop,
	output      sbbn_pkg::result_t result
);

	// Load side to RAM
	logic                wr_en;
	sbbn_pkg::ram_addr_t wr_addr;
	sbbn_pkg::entry_t    wr_data;

	// Emit side to RAM
	logic                rd_en;
	sbbn_pkg::ram_addr_t rd_addr;
	sbbn_pkg::entry_t    rd_data;

	// Job queue
	logic            job_push, job_pop, job_full, job_valid;
	sbbn_pkg::job_t  job_in, job_head;
	sbbn_pkg::jptr_t wr_bank, rd_bank;

	// Hold off new requests while both banks belong to closed drawings
	assign full = job_full;

	sbbn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.point    (point),
		.job_full (job_full),
		.bank     (wr_bank),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.job_push (job_push),
		.job      (job_in)
	);

	sbbn_ram #(
		.WIDTH (sbbn_pkg::ENTRY_W),
		.DEPTH (sbbn_pkg::RAM_DEPTH)
	) u_points (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Queue slot index is the RAM bank of that drawing
	sbbn_job_fifo u_jobs (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.job_in (job_in),
		.pop    (job_pop),
		.full   (job_full),
		.valid  (job_valid),
		.head   (job_head),
		.wr_ptr (wr_bank),
		.rd_ptr (rd_bank)
	);

	sbbn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job_head),
		.job_bank  (rd_bank),
		.job_pop   (job_pop),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

`default_nettype wire
